// File: rtl/eps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes of the encoder period speed meter.
package eps_pkg;

   // Field and datapath widths.
   localparam int COUNT_WIDTH     = 20;
   localparam int SPEED_WIDTH     = 24;
   localparam int NUM_WIDTH       = 32;
   localparam int WEIGHT_WIDTH    = 9;
   localparam int THRESH_WIDTH    = 24;
   localparam int PROD_WIDTH      = WEIGHT_WIDTH + SPEED_WIDTH;
   localparam int BLEND_SHIFT     = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   // Command queue depth between the front and the back; a power of two.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX   = {COUNT_WIDTH{1'b1}};
   localparam logic [SPEED_WIDTH-1:0]  SPEED_MAX   = {SPEED_WIDTH{1'b1}};
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_FULL = WEIGHT_WIDTH'(256);

   // Register values after reset.
   localparam logic [NUM_WIDTH-1:0]    RATE_NUMERATOR_RESET    = NUM_WIDTH'(281600000);
   localparam logic [WEIGHT_WIDTH-1:0] SMOOTH_WEIGHT_RESET     = WEIGHT_WIDTH'(218);
   localparam logic [THRESH_WIDTH-1:0] REPLACE_THRESHOLD_RESET = THRESH_WIDTH'(26);
   localparam logic [COUNT_WIDTH-1:0]  TIMEOUT_TICKS_RESET     = COUNT_WIDTH'(501000);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RATE_NUMERATOR    = 2'd0,
      CSR_SMOOTH_WEIGHT     = 2'd1,
      CSR_REPLACE_THRESHOLD = 2'd2,
      CSR_TIMEOUT_TICKS     = 2'd3
   } eps_csr_type;

   // What the back has to do for one tick.
   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_TIMEOUT = 2'd2
   } eps_op_type;

   typedef struct packed {
      eps_op_type             op;
      logic                   running;
      logic [COUNT_WIDTH-1:0] ticks;
   } eps_cmd_type;

   typedef struct packed {
      logic [NUM_WIDTH-1:0]    rate_numerator;
      logic [WEIGHT_WIDTH-1:0] smooth_weight;
      logic [THRESH_WIDTH-1:0] replace_threshold;
      logic [COUNT_WIDTH-1:0]  timeout_ticks;
   } eps_cfg_type;

endpackage

// File: rtl/eps_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tick beats and speed result beats.
interface eps_req_if;
   logic valid;
   logic ready;
   logic edge_seen;

   modport source (output valid, output edge_seen, input ready);
   modport sink   (input valid, input edge_seen, output ready);
endinterface

interface eps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [eps_pkg::SPEED_WIDTH-1:0]    speed;
   logic                               new_sample;
   logic                               timed_out;
   logic                               running;

   modport source (output valid, output speed, output new_sample, output timed_out,
                   output running, input ready);
   modport sink   (input valid, input speed, input new_sample, input timed_out,
                   input running, output ready);
endinterface

// File: rtl/eps_front.sv
`timescale 1ns / 1ps
// Front end: accepts tick beats, times the notch period and classifies each tick.
module eps_front (
   input  logic                             clock,
   input  logic                             reset,
   eps_req_if.sink                          req_chan,
   input  logic [eps_pkg::COUNT_WIDTH-1:0]  timeout_ticks,
   input  logic                             queue_full,
   output logic                             push,
   output eps_pkg::eps_cmd_type             push_cmd
);

   logic                            timing_ff, timing_in;
   logic [eps_pkg::COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [eps_pkg::COUNT_WIDTH-1:0] elapsed_inc;
   logic                            accept;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push           = accept;

   // Count the tick, then decide between sample, start, timeout and plain hold.
   always_comb begin
      if (timing_ff && (elapsed_ff != eps_pkg::COUNT_MAX)) begin
         elapsed_inc = eps_pkg::COUNT_WIDTH'(elapsed_ff + 1'b1);
      end else begin
         elapsed_inc = elapsed_ff;
      end

      timing_in        = timing_ff;
      elapsed_in       = elapsed_inc;
      push_cmd.op      = eps_pkg::OP_HOLD;
      push_cmd.running = timing_ff;
      push_cmd.ticks   = elapsed_inc;

      if (req_chan.edge_seen) begin
         // An edge always (re)starts the period; it closes one only while timing.
         timing_in        = 1'b1;
         elapsed_in       = '0;
         push_cmd.running = 1'b1;
         if (timing_ff) begin
            push_cmd.op = eps_pkg::OP_SAMPLE;
         end
      end else if (timing_ff && ((elapsed_inc >= timeout_ticks) ||
                                 (elapsed_inc == eps_pkg::COUNT_MAX))) begin
         timing_in        = 1'b0;
         elapsed_in       = '0;
         push_cmd.op      = eps_pkg::OP_TIMEOUT;
         push_cmd.running = 1'b0;
      end
   end

   // Period timer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff  <= 1'b0;
         elapsed_ff <= '0;
      end else if (accept) begin
         timing_ff  <= timing_in;
         elapsed_ff <= elapsed_in;
      end
   end

`ifndef ASSERT_OFF
   // The timer holds zero whenever no period is being timed.
   assert property (@(posedge clock) disable iff (reset)
      !timing_ff |-> (elapsed_ff == '0))
      else $error("elapsed count nonzero while not timing");

   // A sample is only issued with a nonzero period.
   assert property (@(posedge clock) disable iff (reset)
      (push && (push_cmd.op == eps_pkg::OP_SAMPLE)) |-> (push_cmd.ticks != '0))
      else $error("sample issued with zero period");
`endif

endmodule

// File: rtl/eps_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the arithmetic back end.
module eps_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  eps_pkg::eps_cmd_type push_cmd,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output eps_pkg::eps_cmd_type head
);

   localparam int PTR_WIDTH = $clog2(eps_pkg::QUEUE_DEPTH);

   eps_pkg::eps_cmd_type   mem_ff [eps_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH:0]     count_ff, count_in;

   assign full  = (count_ff == (PTR_WIDTH+1)'(eps_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Occupancy after this cycle's push and pop.
   always_comb begin
      count_in = count_ff + {{PTR_WIDTH{1'b0}}, push} - {{PTR_WIDTH{1'b0}}, pop};
   end

   // Pointers and occupancy; pointers wrap naturally at a power-of-two depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= PTR_WIDTH'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= PTR_WIDTH'(rd_ptr_ff + 1'b1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   // Occupancy never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_WIDTH+1)'(eps_pkg::QUEUE_DEPTH))
      else $error("queue overflow");
`endif

endmodule

// File: rtl/eps_back.sv
`timescale 1ns / 1ps
// Back end: serial period divide, speed blend and the result output register.
module eps_back (
   input  logic                 clock,
   input  logic                 reset,
   input  eps_pkg::eps_cfg_type cfg,
   input  logic                 queue_empty,
   input  eps_pkg::eps_cmd_type head,
   output logic                 pop,
   eps_rsp_if.source            rsp_chan
);

   localparam int STEP_WIDTH = $clog2(eps_pkg::NUM_WIDTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIVIDE,
      S_WEIGH,
      S_SUM,
      S_SEND
   } state_type;

   state_type                         state_ff;
   logic [eps_pkg::SPEED_WIDTH-1:0]   speed_ff;
   logic [eps_pkg::NUM_WIDTH-1:0]     quo_ff;
   logic [eps_pkg::COUNT_WIDTH-1:0]   rem_ff;
   logic [eps_pkg::COUNT_WIDTH-1:0]   div_ff;
   logic [STEP_WIDTH-1:0]             step_ff;
   logic                              run_ff;
   logic [eps_pkg::PROD_WIDTH-1:0]    prod_new_ff, prod_new_in;
   logic [eps_pkg::PROD_WIDTH-1:0]    prod_old_ff, prod_old_in;
   logic                              rsp_valid_ff;
   logic [eps_pkg::SPEED_WIDTH-1:0]   rsp_speed_ff;
   logic                              rsp_new_ff;
   logic                              rsp_timeout_ff;
   logic                              rsp_running_ff;

   logic [eps_pkg::COUNT_WIDTH:0]     rem_shift;
   logic                              rem_ge;
   logic [eps_pkg::COUNT_WIDTH-1:0]   rem_in;
   logic [eps_pkg::NUM_WIDTH-1:0]     quo_in;
   logic [eps_pkg::SPEED_WIDTH-1:0]   raw_speed;
   logic [eps_pkg::WEIGHT_WIDTH-1:0]  weight_new;
   logic [eps_pkg::WEIGHT_WIDTH-1:0]  weight_old;
   logic [eps_pkg::PROD_WIDTH:0]      blend_sum;
   logic [eps_pkg::SPEED_WIDTH-1:0]   blend_speed;
   logic                              out_free;
   logic                              rsp_load;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.speed      = rsp_speed_ff;
   assign rsp_chan.new_sample = rsp_new_ff;
   assign rsp_chan.timed_out  = rsp_timeout_ff;
   assign rsp_chan.running    = rsp_running_ff;

   // The output register can take a beat when empty or being drained now.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = (state_ff == S_IDLE) && !queue_empty && out_free;

   // The output register is loaded this cycle by a hold or timeout pop or by a finished sample.
   assign rsp_load = (pop && (head.op != eps_pkg::OP_SAMPLE)) ||
                     ((state_ff == S_SEND) && out_free);

   // One restoring divide step: one quotient bit per cycle.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[eps_pkg::NUM_WIDTH-1]};
      rem_ge    = (rem_shift >= {1'b0, div_ff});
      if (rem_ge) begin
         rem_in = eps_pkg::COUNT_WIDTH'(rem_shift - {1'b0, div_ff});
      end else begin
         rem_in = rem_shift[eps_pkg::COUNT_WIDTH-1:0];
      end
      quo_in = {quo_ff[eps_pkg::NUM_WIDTH-2:0], rem_ge};
   end

   // Saturate the quotient and form the two weighted products.
   always_comb begin
      if (|quo_ff[eps_pkg::NUM_WIDTH-1:eps_pkg::SPEED_WIDTH]) begin
         raw_speed = eps_pkg::SPEED_MAX;
      end else begin
         raw_speed = quo_ff[eps_pkg::SPEED_WIDTH-1:0];
      end
      if (cfg.smooth_weight > eps_pkg::WEIGHT_FULL) begin
         weight_new = eps_pkg::WEIGHT_FULL;
      end else begin
         weight_new = cfg.smooth_weight;
      end
      weight_old  = eps_pkg::WEIGHT_WIDTH'(eps_pkg::WEIGHT_FULL - weight_new);
      prod_new_in = eps_pkg::PROD_WIDTH'(weight_new) * eps_pkg::PROD_WIDTH'(raw_speed);
      prod_old_in = eps_pkg::PROD_WIDTH'(weight_old) * eps_pkg::PROD_WIDTH'(speed_ff);
      blend_sum   = {1'b0, prod_new_ff} + {1'b0, prod_old_ff};
      blend_speed = blend_sum[eps_pkg::BLEND_SHIFT +: eps_pkg::SPEED_WIDTH];
   end

   // Sequencer, speed state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  unique case (head.op)
                     eps_pkg::OP_SAMPLE: begin
                        quo_ff   <= cfg.rate_numerator;
                        rem_ff   <= '0;
                        div_ff   <= head.ticks;
                        step_ff  <= STEP_WIDTH'(eps_pkg::NUM_WIDTH);
                        run_ff   <= head.running;
                        state_ff <= S_DIVIDE;
                     end
                     eps_pkg::OP_TIMEOUT: begin
                        speed_ff       <= '0;
                        rsp_valid_ff   <= 1'b1;
                        rsp_speed_ff   <= '0;
                        rsp_new_ff     <= 1'b0;
                        rsp_timeout_ff <= 1'b1;
                        rsp_running_ff <= head.running;
                     end
                     default: begin
                        rsp_valid_ff   <= 1'b1;
                        rsp_speed_ff   <= speed_ff;
                        rsp_new_ff     <= 1'b0;
                        rsp_timeout_ff <= 1'b0;
                        rsp_running_ff <= head.running;
                     end
                  endcase
               end
            end
            S_DIVIDE: begin
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
               step_ff <= STEP_WIDTH'(step_ff - 1'b1);
               if (step_ff == STEP_WIDTH'(1)) begin
                  state_ff <= S_WEIGH;
               end
            end
            S_WEIGH: begin
               // While the stored speed is below the threshold it is replaced, not averaged.
               if (speed_ff < cfg.replace_threshold) begin
                  speed_ff <= raw_speed;
                  state_ff <= S_SEND;
               end else begin
                  prod_new_ff <= prod_new_in;
                  prod_old_ff <= prod_old_in;
                  state_ff    <= S_SUM;
               end
            end
            S_SUM: begin
               speed_ff <= blend_speed;
               state_ff <= S_SEND;
            end
            S_SEND: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_speed_ff   <= speed_ff;
                  rsp_new_ff     <= 1'b1;
                  rsp_timeout_ff <= 1'b0;
                  rsp_running_ff <= run_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   // A timeout beat always reports zero speed and a stopped timer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_timeout_ff) |-> ((rsp_speed_ff == '0) && !rsp_running_ff))
      else $error("timeout beat with speed or running set");

   // A beat is never both a new sample and a timeout.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_timeout_ff))
      else $error("sample and timeout flagged together");

   // The queue is only drained while the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> ((state_ff == S_IDLE) && !queue_empty))
      else $error("pop outside idle or from empty queue");
`endif

endmodule

// File: rtl/encoder_period_speed_meter.sv
`timescale 1ns / 1ps
// Encoder period speed meter: one wheel channel, top level with the register file.
//
// Each beat on req_chan is one timebase tick, with edge_seen set when an encoder
// notch edge fell in it. Every tick gives exactly one beat on rsp_chan carrying
// the current speed (unsigned Q8 cm/s) and the new_sample, timed_out and running
// flags. The first edge starts timing; each later edge divides rate_numerator by
// the elapsed ticks and blends or replaces the speed; reaching timeout_ticks
// zeroes the speed and stops timing.
// Path: every tick passes through the command queue and the output register; a sample
// tick also runs through the bit-serial divide, the multiply step, the add step (skipped
// when the speed is replaced outright) and the send step before its beat is offered.
// The back takes no further tick until a sample tick's beat is sent; other ticks go
// one per cycle while rsp_chan is ready.
// A two-entry command queue lets the front take ticks while the back works.
// A stalled rsp_chan holds its beat; once the queue fills, req_chan.ready drops.
// Reset clears the timer, the speed and both channels and loads the register
// reset values. Write registers through csr_* only while the block is idle; the block does not enforce this.
module encoder_period_speed_meter (
   input  logic                                 clock,
   input  logic                                 reset,
   eps_req_if.sink                              req_chan,
   eps_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [eps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [eps_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   eps_pkg::eps_cfg_type cfg_ff;
   eps_pkg::eps_cmd_type push_cmd;
   eps_pkg::eps_cmd_type head;
   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 queue_empty;

   // Configuration register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_numerator    <= eps_pkg::RATE_NUMERATOR_RESET;
         cfg_ff.smooth_weight     <= eps_pkg::SMOOTH_WEIGHT_RESET;
         cfg_ff.replace_threshold <= eps_pkg::REPLACE_THRESHOLD_RESET;
         cfg_ff.timeout_ticks     <= eps_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_write_en) begin
         unique case (eps_pkg::eps_csr_type'(csr_index))
            eps_pkg::CSR_RATE_NUMERATOR: begin
               cfg_ff.rate_numerator <= csr_wdata[eps_pkg::NUM_WIDTH-1:0];
            end
            eps_pkg::CSR_SMOOTH_WEIGHT: begin
               cfg_ff.smooth_weight <= csr_wdata[eps_pkg::WEIGHT_WIDTH-1:0];
            end
            eps_pkg::CSR_REPLACE_THRESHOLD: begin
               cfg_ff.replace_threshold <= csr_wdata[eps_pkg::THRESH_WIDTH-1:0];
            end
            eps_pkg::CSR_TIMEOUT_TICKS: begin
               cfg_ff.timeout_ticks <= csr_wdata[eps_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   eps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .timeout_ticks (cfg_ff.timeout_ticks),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   eps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   eps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

// File: test/eps_speed_checker.sv
`timescale 1ns / 1ps
// Checker for the encoder period speed meter: predicts each result beat and compares it.
module eps_speed_checker (
   input  logic                                clock,
   input  logic                                reset,
   eps_req_if                                  req_mon,
   eps_rsp_if                                  rsp_mon,
   input  logic                                csr_write_en,
   input  logic [eps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [eps_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding
);

   typedef struct packed {
      logic [eps_pkg::SPEED_WIDTH-1:0] speed;
      logic                            new_sample;
      logic                            timed_out;
      logic                            running;
   } speed_beat_type;

   // Shadow copy of the register file.
   logic [eps_pkg::NUM_WIDTH-1:0]    rate_num;
   logic [eps_pkg::WEIGHT_WIDTH-1:0] blend_weight;
   logic [eps_pkg::THRESH_WIDTH-1:0] replace_level;
   logic [eps_pkg::COUNT_WIDTH-1:0]  timeout_limit;

   // Shadow copy of the period timer and the speed.
   logic                             timing;
   logic [eps_pkg::COUNT_WIDTH-1:0]  elapsed;
   logic [eps_pkg::SPEED_WIDTH-1:0]  speed_now;

   speed_beat_type                   speed_q[$];

   // Advance the timer by one tick and return the beat the block should send for it.
   function automatic speed_beat_type advance_meter(input logic notch);
      speed_beat_type beat;
      logic [63:0] raw;
      logic [63:0] wt;
      logic [63:0] blend;
      beat = '0;
      if (timing && elapsed != eps_pkg::COUNT_MAX) begin
         elapsed = elapsed + 1'b1;
      end
      if (notch) begin
         if (timing) begin
            // The elapsed count is at least one here, so the divide is safe.
            raw = 64'(rate_num) / 64'(elapsed);
            if (raw > 64'(eps_pkg::SPEED_MAX)) begin
               raw = 64'(eps_pkg::SPEED_MAX);
            end
            wt = (blend_weight > eps_pkg::WEIGHT_FULL) ? 64'd256 : 64'(blend_weight);
            if (speed_now < replace_level) begin
               speed_now = raw[eps_pkg::SPEED_WIDTH-1:0];
            end else begin
               blend = (wt * raw + (64'd256 - wt) * 64'(speed_now)) >> eps_pkg::BLEND_SHIFT;
               speed_now = blend[eps_pkg::SPEED_WIDTH-1:0];
            end
            elapsed = '0;
            beat.new_sample = 1'b1;
         end else begin
            timing = 1'b1;
            elapsed = '0;
         end
      end else if (timing && (elapsed >= timeout_limit || elapsed == eps_pkg::COUNT_MAX)) begin
         // No edge in time: the wheel is taken as stopped.
         speed_now = '0;
         timing = 1'b0;
         elapsed = '0;
         beat.timed_out = 1'b1;
      end
      beat.speed = speed_now;
      beat.running = timing;
      return beat;
   endfunction

   task automatic compare_beat(input speed_beat_type want, input speed_beat_type got);
      if (got.speed !== want.speed) begin
         $display("%0t: speed mismatch: expected %0d, actual %0d", $time,
                  want.speed, got.speed);
         mismatches++;
      end
      if (got.new_sample !== want.new_sample) begin
         $display("%0t: new_sample mismatch: expected %0b, actual %0b", $time,
                  want.new_sample, got.new_sample);
         mismatches++;
      end
      if (got.timed_out !== want.timed_out) begin
         $display("%0t: timed_out mismatch: expected %0b, actual %0b", $time,
                  want.timed_out, got.timed_out);
         mismatches++;
      end
      if (got.running !== want.running) begin
         $display("%0t: running mismatch: expected %0b, actual %0b", $time,
                  want.running, got.running);
         mismatches++;
      end
   endtask

   // Follow register writes, tick beats and result beats at each rising edge.
   always @(posedge clock) begin
      speed_beat_type got;
      if (reset) begin
         rate_num      = eps_pkg::RATE_NUMERATOR_RESET;
         blend_weight  = eps_pkg::SMOOTH_WEIGHT_RESET;
         replace_level = eps_pkg::REPLACE_THRESHOLD_RESET;
         timeout_limit = eps_pkg::TIMEOUT_TICKS_RESET;
         timing        = 1'b0;
         elapsed       = '0;
         speed_now     = '0;
         speed_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_write_en) begin
            case (eps_pkg::eps_csr_type'(csr_index))
               eps_pkg::CSR_RATE_NUMERATOR:
                  rate_num      = csr_wdata[eps_pkg::NUM_WIDTH-1:0];
               eps_pkg::CSR_SMOOTH_WEIGHT:
                  blend_weight  = csr_wdata[eps_pkg::WEIGHT_WIDTH-1:0];
               eps_pkg::CSR_REPLACE_THRESHOLD:
                  replace_level = csr_wdata[eps_pkg::THRESH_WIDTH-1:0];
               eps_pkg::CSR_TIMEOUT_TICKS:
                  timeout_limit = csr_wdata[eps_pkg::COUNT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.speed      = rsp_mon.speed;
            got.new_sample = rsp_mon.new_sample;
            got.timed_out  = rsp_mon.timed_out;
            got.running    = rsp_mon.running;
            if (speed_q.size() == 0) begin
               $display("%0t: result beat with none expected: expected nothing, actual %h",
                        $time, got);
               mismatches++;
            end else begin
               compare_beat(speed_q.pop_front(), got);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            speed_q.push_back(advance_meter(req_mon.edge_seen));
         end
         outstanding <= speed_q.size();
      end
   end

endmodule

// File: test/encoder_period_speed_meter_tb.sv
`timescale 1ns / 1ps
// Testbench top of the encoder period speed meter: tick stimulus, settings and verdict.
module encoder_period_speed_meter_tb;

   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 12;
   localparam int PHASE_TICKS   = 85;

   logic                               clock;
   logic                               reset;
   logic                               csr_write_en;
   eps_pkg::eps_csr_type               csr_index;
   logic [eps_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;
   int                                 mismatches;
   int                                 outstanding;

   // Random idling control; calm turns it off for the last part of the run.
   bit                        calm;
   int                        send_pct;
   int                        stall_pct;
   int                        stall_left;
   int                        watchdog_cycles;

   eps_req_if req_chan ();
   eps_rsp_if rsp_chan ();

   encoder_period_speed_meter dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   eps_speed_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: ready drops in random bursts.
   initial begin
      stall_left = 0;
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 3);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Send one tick beat, sometimes after a short idle burst.
   task automatic send_tick(input logic notch);
      int gap;
      if (!calm && $urandom_range(0, 99) < send_pct) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.edge_seen <= notch;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // Send a fixed run of ticks, leftmost bit first.
   task automatic send_pattern(input logic [31:0] bits, input int count);
      for (int i = count - 1; i >= 0; i--) begin
         send_tick(bits[i]);
      end
   endtask

   // Hold off until every result beat has come back, then let the block settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers on consecutive cycles; the block must be idle.
   task automatic load_settings(input logic [eps_pkg::NUM_WIDTH-1:0] num,
                                input logic [eps_pkg::WEIGHT_WIDTH-1:0] wt,
                                input logic [eps_pkg::THRESH_WIDTH-1:0] thr,
                                input logic [eps_pkg::COUNT_WIDTH-1:0] tmo);
      csr_write_en <= 1'b1;
      csr_index    <= eps_pkg::CSR_RATE_NUMERATOR;
      csr_wdata    <= eps_pkg::CSR_DATA_WIDTH'(num);
      @(posedge clock);
      csr_index    <= eps_pkg::CSR_SMOOTH_WEIGHT;
      csr_wdata    <= eps_pkg::CSR_DATA_WIDTH'(wt);
      @(posedge clock);
      csr_index    <= eps_pkg::CSR_REPLACE_THRESHOLD;
      csr_wdata    <= eps_pkg::CSR_DATA_WIDTH'(thr);
      @(posedge clock);
      csr_index    <= eps_pkg::CSR_TIMEOUT_TICKS;
      csr_wdata    <= eps_pkg::CSR_DATA_WIDTH'(tmo);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Draw a random setting, biased toward small timeouts so that stops happen often.
   task automatic pick_settings(output logic [eps_pkg::COUNT_WIDTH-1:0] tmo);
      logic [eps_pkg::NUM_WIDTH-1:0]    num;
      logic [eps_pkg::WEIGHT_WIDTH-1:0] wt;
      logic [eps_pkg::THRESH_WIDTH-1:0] thr;
      case ($urandom_range(0, 4))
         0:       num = $urandom;
         1:       num = '1;
         2:       num = $urandom_range(1000, 300000000);
         3:       num = $urandom_range(0, 5000);
         default: num = eps_pkg::RATE_NUMERATOR_RESET;
      endcase
      if ($urandom_range(0, 3) == 0) begin
         wt = eps_pkg::WEIGHT_WIDTH'($urandom_range(257, 511));
      end else begin
         wt = eps_pkg::WEIGHT_WIDTH'($urandom_range(0, 256));
      end
      case ($urandom_range(0, 3))
         0:       thr = '0;
         1:       thr = '1;
         2:       thr = eps_pkg::THRESH_WIDTH'($urandom_range(0, 2000));
         default: thr = eps_pkg::THRESH_WIDTH'($urandom_range(0, 24'hFF_FFFF));
      endcase
      case ($urandom_range(0, 9))
         0:       tmo = '0;
         1:       tmo = '1;
         2:       tmo = eps_pkg::COUNT_WIDTH'(1);
         default: tmo = eps_pkg::COUNT_WIDTH'($urandom_range(1, 48));
      endcase
      load_settings(num, wt, thr, tmo);
   endtask

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 40;
      endcase
   endfunction

   // Stimulus: directed ticks first, then random phases with random settings.
   initial begin
      logic [eps_pkg::COUNT_WIDTH-1:0] tmo;
      int gap_top;
      int gap;
      int sent;
      calm      = 1'b0;
      send_pct  = 0;
      stall_pct = 0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.edge_seen <= 1'b0;
      csr_write_en       <= 1'b0;
      csr_index          <= eps_pkg::CSR_RATE_NUMERATOR;
      csr_wdata          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: an idle tick, a start, then a saturating first period.
      send_pattern(32'b01011, 5);
      drain();
      // Zero numerator, weight above full scale, zero timeout.
      load_settings('0, 9'd511, '0, '0);
      send_pattern(32'b1011, 4);
      drain();
      // Largest numerator, zero weight, largest threshold, edge on the timeout tick.
      load_settings('1, '0, '1, eps_pkg::COUNT_WIDTH'(3));
      send_pattern(32'b00010011, 8);
      drain();
      // Full weight and the longest timeout.
      load_settings(eps_pkg::RATE_NUMERATOR_RESET, eps_pkg::WEIGHT_FULL,
                    eps_pkg::REPLACE_THRESHOLD_RESET, '1);
      send_pattern(32'b0000011, 7);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         calm      = (ph == PHASES - 1);
         send_pct  = calm ? 0 : pick_pct();
         stall_pct = calm ? 0 : pick_pct();
         pick_settings(tmo);
         gap_top = (tmo < 48) ? int'(tmo) + 2 : 48;
         sent = 0;
         while (sent < PHASE_TICKS) begin
            if ($urandom_range(0, 9) < 8) begin
               // Well-formed: an edge followed by a run of quiet ticks.
               send_tick(1'b1);
               gap = $urandom_range(0, gap_top);
               repeat (gap) send_tick(1'b0);
               sent += gap + 1;
            end else begin
               gap = $urandom_range(1, 6);
               repeat (gap) send_tick(1'($urandom_range(0, 1)));
               sent += gap;
            end
         end
      end
      drain();

      if (mismatches == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      watchdog_cycles = 0;
      while (watchdog_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         watchdog_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/eps_pkg.sv
rtl/eps_chan_if.sv
rtl/eps_front.sv
rtl/eps_queue.sv
rtl/eps_back.sv
rtl/encoder_period_speed_meter.sv
test/eps_speed_checker.sv
test/encoder_period_speed_meter_tb.sv
